// File: hdl/tpfp_pkg.sv
package tpfp_pkg;

    // width of the saturating byte position counter
    localparam int POSITION_BITS = 16;

    // parser phases
    typedef enum logic [2:0] {
        PH_VERSION = 3'd0,
        PH_TAG     = 3'd1,
        PH_VALUE   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_BODY    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    // status codes reported on the last byte
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_VERSION = 3'd2,
        ST_VARINT  = 3'd3,
        ST_OVERRUN = 3'd4,
        ST_WIRE    = 3'd5
    } status_t;

    // wire types understood by the parser
    localparam logic [2:0] WIRE_SCALAR = 3'd0;
    localparam logic [2:0] WIRE_LEN    = 3'd2;

    // field numbers with a meaning
    localparam logic [4:0] FIELD_INDEX  = 5'd1;
    localparam logic [4:0] FIELD_CIPHER = 5'd2;

    // varint limits
    localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

    // reset value of the expected version register
    localparam logic [7:0] VERSION_RESET = 8'd3;

    // packed width of the result data word (fields plus zero fill to bytes)
    localparam int RES_FIELD_BITS = 8 + 3 + 32 + 16 + 16;
    localparam int RES_DATA_BITS  = ((RES_FIELD_BITS + 7) / 8) * 8;

    // one result item
    typedef struct packed {
        logic        cipher_valid;
        logic [7:0]  cipher_byte;
        logic        done_res;
        status_t     status;
        logic [31:0] msg_number;
        logic [15:0] cipher_start;
        logic [15:0] cipher_length;
    } result_t;

endpackage

// File: hdl/tpfp_in_stage.sv
module tpfp_in_stage import tpfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // free when empty or when the held byte moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded on each transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

// File: hdl/tpfp_parser.sv
module tpfp_parser import tpfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic [7:0] expected_version,
    output logic       res_valid,
    output result_t    res
);

    phase_t                   phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [31:0]              accum_reg, accum_next;
    logic [2:0]               count_reg, count_next;
    logic [4:0]               field_reg, field_next;
    logic [2:0]               wire_reg, wire_next;
    logic [31:0]              remain_reg, remain_next;
    logic [31:0]              index_reg, index_next;
    logic [15:0]              start_reg, start_next;
    logic [15:0]              length_reg, length_next;
    status_t                  error_reg, error_next;

    logic [31:0] acc_new;
    logic [2:0]  count_new;
    logic [31:0] remain_dec;
    logic [32:0] pos_inc;
    logic [15:0] pos_inc_sat;
    logic [15:0] acc_sat;
    logic        cvalid;
    status_t     status_w;

    // bit offset of the current 7-bit varint group
    function automatic logic [4:0] group_shift(input logic [2:0] cnt);
        logic [4:0] s;
        begin
            case (cnt)
                3'd0:    s = 5'd0;
                3'd1:    s = 5'd7;
                3'd2:    s = 5'd14;
                3'd3:    s = 5'd21;
                default: s = 5'd28;
            endcase
            return s;
        end
    endfunction

    // shared arithmetic
    assign acc_new     = accum_reg | (32'(data_byte[6:0]) << group_shift(count_reg));
    assign count_new   = count_reg + 3'd1;
    assign remain_dec  = remain_reg - 32'd1;
    assign pos_inc     = 33'(pos_reg) + 33'd1;
    assign pos_inc_sat = (pos_inc > 33'h0FFFF) ? 16'hFFFF : pos_inc[15:0];
    assign acc_sat     = (acc_new > 32'h0000FFFF) ? 16'hFFFF : acc_new[15:0];

    // per-byte parse step
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        accum_next  = accum_reg;
        count_next  = count_reg;
        field_next  = field_reg;
        wire_next   = wire_reg;
        remain_next = remain_reg;
        index_next  = index_reg;
        start_next  = start_reg;
        length_next = length_reg;
        error_next  = error_reg;
        cvalid      = 1'b0;

        case (phase_reg)
            PH_VERSION:
            begin
                if (data_byte != expected_version)
                begin
                    error_next = ST_VERSION;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    phase_next = PH_TAG;
                end
            end
            PH_TAG:
            begin
                field_next = data_byte[7:3];
                wire_next  = data_byte[2:0];
                accum_next = 32'd0;
                count_next = 3'd0;
                if (data_byte[2:0] == WIRE_SCALAR)
                begin
                    phase_next = PH_VALUE;
                end
                else if (data_byte[2:0] == WIRE_LEN)
                begin
                    phase_next = PH_LENGTH;
                end
                else
                begin
                    error_next = ST_WIRE;
                    phase_next = PH_ERROR;
                end
            end
            PH_VALUE, PH_LENGTH:
            begin
                accum_next = acc_new;
                count_next = count_new;
                if (data_byte[7])
                begin
                    if (count_new >= VARINT_MAX_BYTES)
                    begin
                        error_next = ST_VARINT;
                        phase_next = PH_ERROR;
                    end
                end
                else if (phase_reg == PH_VALUE)
                begin
                    if (field_reg == FIELD_INDEX)
                    begin
                        index_next = acc_new;
                    end
                    phase_next = PH_TAG;
                end
                else
                begin
                    if (field_reg == FIELD_CIPHER)
                    begin
                        start_next  = pos_inc_sat;
                        length_next = acc_sat;
                    end
                    remain_next = acc_new;
                    phase_next  = (acc_new != 32'd0) ? PH_BODY : PH_TAG;
                end
            end
            PH_BODY:
            begin
                cvalid      = (field_reg == FIELD_CIPHER);
                remain_next = remain_dec;
                if (remain_dec == 32'd0)
                begin
                    phase_next = PH_TAG;
                end
            end
            default:
            begin
            end
        endcase

        // closing status, taken from the phase after this byte unless the buffer is short
        if (pos_reg < POSITION_BITS'(2))
        begin
            status_w = ST_SHORT;
        end
        else if (phase_next == PH_ERROR)
        begin
            status_w = error_next;
        end
        else if (phase_next == PH_VALUE || phase_next == PH_LENGTH)
        begin
            status_w = ST_VARINT;
        end
        else if (phase_next == PH_BODY)
        begin
            status_w = ST_OVERRUN;
        end
        else
        begin
            status_w = ST_OK;
        end

        // result item
        res_valid         = cvalid || last_byte;
        res.cipher_valid  = cvalid;
        res.cipher_byte   = cvalid ? data_byte : 8'd0;
        res.done_res      = last_byte;
        res.status        = last_byte ? status_w : ST_OK;
        res.msg_number    = last_byte ? index_next : 32'd0;
        res.cipher_start  = last_byte ? start_next : 16'd0;
        res.cipher_length = last_byte ? length_next : 16'd0;

        // end of buffer: back to the start, otherwise count the byte
        if (last_byte)
        begin
            phase_next  = PH_VERSION;
            pos_next    = '0;
            accum_next  = 32'd0;
            count_next  = 3'd0;
            field_next  = 5'd0;
            wire_next   = 3'd0;
            remain_next = 32'd0;
            index_next  = 32'd0;
            start_next  = 16'd0;
            length_next = 16'd0;
            error_next  = ST_OK;
        end
        else if (pos_reg != '1)
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    // parser state, updated once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_VERSION;
            pos_reg    <= '0;
            accum_reg  <= 32'd0;
            count_reg  <= 3'd0;
            field_reg  <= 5'd0;
            wire_reg   <= 3'd0;
            remain_reg <= 32'd0;
            index_reg  <= 32'd0;
            start_reg  <= 16'd0;
            length_reg <= 16'd0;
            error_reg  <= ST_OK;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            accum_reg  <= accum_next;
            count_reg  <= count_next;
            field_reg  <= field_next;
            wire_reg   <= wire_next;
            remain_reg <= remain_next;
            index_reg  <= index_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            error_reg  <= error_next;
        end
    end

`ifndef ASSERT_OFF
    // a closing byte leaves the parser at the start of a new buffer
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_byte |=> phase_reg == PH_VERSION && pos_reg == '0)
        else $error("parser did not restart after last byte");

    // an error holds until the end of the buffer
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_byte && phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("error phase left before last byte");

    // cipher bytes only come from a field 2 body
    a_cipher_src: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.cipher_valid |-> phase_reg == PH_BODY && field_reg == FIELD_CIPHER)
        else $error("cipher byte outside a field 2 body");

    // the final body byte returns to tag parsing
    a_body_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_byte && phase_reg == PH_BODY && remain_reg == 32'd1
        |=> phase_reg == PH_TAG)
        else $error("body did not end on its last byte");
`endif

endmodule

// File: hdl/tpfp_out_stage.sv
module tpfp_out_stage import tpfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_res,
    output logic    can_take,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // room when empty or when the held result leaves this cycle
    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: hdl/tagged_payload_field_parser.sv
// Tagged payload field parser.
// Slave stream s_axis: one payload byte per transfer in tdata, tlast on the
// final byte of a buffer. Master stream m_axis: one result per transfer; a
// result is sent for every field 2 body byte (tuser = 1, byte in tdata[7:0])
// and for every last byte (tlast = 1, status and summary fields in tdata).
// Both may share one transfer. Other bytes produce no result.
// Configuration: cfg_valid/cfg_ready/cfg_data writes the expected version
// byte (reset value 3); cfg_ready is always high. Write it only while idle.
// Throughput: one byte per clock while m_axis_tready is high. A byte goes
// through an input register, combinational parse logic and a result
// register, from which its result is offered on m_axis.
// Back-pressure: while m_axis_tready is low the held result stays put and
// the input register can still take one more byte; the stream stalls when
// both registers are full.
// Reset (rst_n low, asynchronous) empties both registers, returns the
// parser to expect the version byte and sets the expected version to 3.
module tagged_payload_field_parser import tpfp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // [7:0] data_byte
    input  logic                     s_axis_tlast,  // last_byte
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [7:0] cipher_byte, [10:8] status, [42:11] msg_number,
    // [58:43] cipher_start, [74:59] cipher_length, [79:75] zero
    output logic [RES_DATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tlast,  // done_res
    output logic                     m_axis_tuser,  // cipher_valid
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [7:0]               cfg_data
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_last;
    logic       advance;
    logic       can_take;
    logic       res_valid;
    result_t    res;
    result_t    out_res;
    logic [7:0] version_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= VERSION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            version_reg <= cfg_data;
        end
    end

    // held byte moves on when the result register has room
    assign advance = held_valid && can_take;

    tpfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    tpfp_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .data_byte        (held_byte),
        .last_byte        (held_last),
        .expected_version (version_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    tpfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_res  (res),
        .can_take  (can_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // pack the result fields, cipher_byte in the lowest bits
    assign m_axis_tdata = {
        (RES_DATA_BITS - RES_FIELD_BITS)'(0),
        out_res.cipher_length,
        out_res.cipher_start,
        out_res.msg_number,
        out_res.status,
        out_res.cipher_byte
    };
    assign m_axis_tlast = out_res.done_res;
    assign m_axis_tuser = out_res.cipher_valid;

endmodule
